[sv/afrg_pkg.sv]
`timescale 1ns / 1ps

package afrg_pkg;

    localparam int RING_DEPTH_DEF    = 64;
    localparam int WARMUP_ROUNDS_DEF = 10;

    localparam int WORD_W = 32;
    localparam int OUT_W  = 31;
    localparam int CODE_W = 3;
    localparam int DEG_W  = 6;

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [DEG_W-1:0]  degree_t;

    localparam code_t CODE_D0    = 3'd0;
    localparam code_t CODE_D7    = 3'd1;
    localparam code_t CODE_D15   = 3'd2;
    localparam code_t CODE_D31   = 3'd3;
    localparam code_t CODE_D63   = 3'd4;
    localparam code_t CODE_RESET = CODE_D31;

    localparam logic [WORD_W-1:0] SEED_RESET  = 32'd1;
    localparam logic [WORD_W-1:0] LCG_S_MUL   = 32'd1103515245;
    localparam logic [WORD_W-1:0] LCG_S_INC   = 32'd12345;
    localparam logic [63:0]       LCG_L_MUL   = 64'd6364136223846793005;
    localparam logic [WORD_W-1:0] LCG_L_MUL_LO = LCG_L_MUL[31:0];
    localparam logic [WORD_W-1:0] LCG_L_MUL_HI = LCG_L_MUL[63:32];

    typedef enum logic [3:0] {
        ST_BOOT,
        ST_IDLE,
        ST_SETUP,
        ST_FILL,
        ST_SMUL,
        ST_SNEXT,
        ST_WP0,
        ST_WP1,
        ST_WP2,
        ST_WNEXT,
        ST_WARM_RD,
        ST_WARM_WR,
        ST_DRAW_RD,
        ST_DRAW_WR,
        ST_D0_MUL,
        ST_D0_NEXT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_SMALL,
        OP_NEXT_SMALL,
        OP_MUL_P0,
        OP_MUL_P1,
        OP_MUL_P2,
        OP_NEXT_WIDE,
        OP_FILL_WR,
        OP_DRAW_RD,
        OP_DRAW_WR
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   boot;
        logic   warm;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic deg_zero;
        logic wide;
        logic fill_last;
        logic warm_last;
    } dp_sts_t;

    function automatic code_t sat_code(input code_t c);
        return (c > CODE_D63) ? CODE_D63 : c;
    endfunction

    function automatic degree_t degree_of(input code_t c);
        degree_t d;
        unique case (c)
            CODE_D0:  d = DEG_W'(0);
            CODE_D7:  d = DEG_W'(7);
            CODE_D15: d = DEG_W'(15);
            CODE_D31: d = DEG_W'(31);
            default:  d = DEG_W'(63);
        endcase
        return d;
    endfunction

endpackage

[sv/additive_feedback_random_generator.sv]
`timescale 1ns / 1ps

// Additive-feedback random generator. Each input word is a draw (s_req_type 0), returning
// one 31-bit number, or a reseed (s_req_type 1), returning nothing. A draw is accepted in
// idle, then reads the front and rear words from the two-read-port ring memory, then adds
// them and writes the sum back, where the result is registered. Degree 0 draws instead
// run the small LCG on the shared 32x32 multiplier. A result still waiting for m_ready
// holds the next draw in its write-back cycle. A reseed fills the ring with D words
// (D = degree) from the small LCG for degree 7 or 31 or from the 64-bit LCG for degree
// 15 or 63 (three partial products on the one multiplier), then warms up by discarding
// WARMUP_ROUNDS*D draws. After reset the block seeds itself with 1 at degree 31, with
// s_ready low until the seeding is done. degree_select is sampled at the next reseed.

module additive_feedback_random_generator #(
    parameter int RING_DEPTH    = afrg_pkg::RING_DEPTH_DEF,
    parameter int WARMUP_ROUNDS = afrg_pkg::WARMUP_ROUNDS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [afrg_pkg::CODE_W-1:0]  cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_req_type,
    input  logic [afrg_pkg::WORD_W-1:0]  s_seed_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [afrg_pkg::OUT_W-1:0]   m_random_value
);

    afrg_pkg::dp_cmd_t cmd;
    afrg_pkg::dp_sts_t sts;

    afrg_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .cmd        (cmd),
        .sts        (sts)
    );

    afrg_datapath #(
        .RING_DEPTH    (RING_DEPTH),
        .WARMUP_ROUNDS (WARMUP_ROUNDS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .seed_value   (s_seed_value),
        .cmd          (cmd),
        .sts          (sts),
        .random_value (m_random_value)
    );

endmodule

[sv/afrg_ctrl.sv]
`timescale 1ns / 1ps

module afrg_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_req_type,
    output logic              m_valid,
    input  logic              m_ready,
    output afrg_pkg::dp_cmd_t cmd,
    input  afrg_pkg::dp_sts_t sts
);

    afrg_pkg::state_t state_reg;
    afrg_pkg::state_t state_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic             out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == afrg_pkg::ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= afrg_pkg::ST_BOOT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd.op       = afrg_pkg::OP_NONE;
        cmd.boot     = 1'b0;
        cmd.warm     = 1'b0;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            afrg_pkg::ST_BOOT: begin
                cmd.op     = afrg_pkg::OP_LOAD;
                cmd.boot   = 1'b1;
                state_next = afrg_pkg::ST_SETUP;
            end
            afrg_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_req_type) begin
                        cmd.op     = afrg_pkg::OP_LOAD;
                        state_next = afrg_pkg::ST_SETUP;
                    end else if (sts.deg_zero) begin
                        state_next = afrg_pkg::ST_D0_MUL;
                    end else begin
                        state_next = afrg_pkg::ST_DRAW_RD;
                    end
                end
            end
            afrg_pkg::ST_SETUP: begin
                state_next = sts.deg_zero ? afrg_pkg::ST_IDLE : afrg_pkg::ST_FILL;
            end
            afrg_pkg::ST_FILL: begin
                cmd.op = afrg_pkg::OP_FILL_WR;
                if (sts.fill_last) begin
                    state_next = afrg_pkg::ST_WARM_RD;
                end else if (sts.wide) begin
                    state_next = afrg_pkg::ST_WP0;
                end else begin
                    state_next = afrg_pkg::ST_SMUL;
                end
            end
            afrg_pkg::ST_SMUL: begin
                cmd.op     = afrg_pkg::OP_MUL_SMALL;
                state_next = afrg_pkg::ST_SNEXT;
            end
            afrg_pkg::ST_SNEXT: begin
                cmd.op     = afrg_pkg::OP_NEXT_SMALL;
                state_next = afrg_pkg::ST_FILL;
            end
            afrg_pkg::ST_WP0: begin
                cmd.op     = afrg_pkg::OP_MUL_P0;
                state_next = afrg_pkg::ST_WP1;
            end
            afrg_pkg::ST_WP1: begin
                cmd.op     = afrg_pkg::OP_MUL_P1;
                state_next = afrg_pkg::ST_WP2;
            end
            afrg_pkg::ST_WP2: begin
                cmd.op     = afrg_pkg::OP_MUL_P2;
                state_next = afrg_pkg::ST_WNEXT;
            end
            afrg_pkg::ST_WNEXT: begin
                cmd.op     = afrg_pkg::OP_NEXT_WIDE;
                state_next = afrg_pkg::ST_FILL;
            end
            afrg_pkg::ST_WARM_RD: begin
                cmd.op     = afrg_pkg::OP_DRAW_RD;
                state_next = afrg_pkg::ST_WARM_WR;
            end
            afrg_pkg::ST_WARM_WR: begin
                cmd.op     = afrg_pkg::OP_DRAW_WR;
                cmd.warm   = 1'b1;
                state_next = sts.warm_last ? afrg_pkg::ST_IDLE : afrg_pkg::ST_WARM_RD;
            end
            afrg_pkg::ST_DRAW_RD: begin
                cmd.op     = afrg_pkg::OP_DRAW_RD;
                state_next = afrg_pkg::ST_DRAW_WR;
            end
            afrg_pkg::ST_DRAW_WR: begin
                if (out_free) begin
                    cmd.op       = afrg_pkg::OP_DRAW_WR;
                    cmd.out_load = 1'b1;
                    state_next   = afrg_pkg::ST_IDLE;
                end
            end
            afrg_pkg::ST_D0_MUL: begin
                cmd.op     = afrg_pkg::OP_MUL_SMALL;
                state_next = afrg_pkg::ST_D0_NEXT;
            end
            afrg_pkg::ST_D0_NEXT: begin
                if (out_free) begin
                    cmd.op       = afrg_pkg::OP_NEXT_SMALL;
                    cmd.out_load = 1'b1;
                    state_next   = afrg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = afrg_pkg::ST_BOOT;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free)
        else $error("result word loaded over an untaken word");

    a_valid_from_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |->
            $past(state_reg == afrg_pkg::ST_DRAW_WR || state_reg == afrg_pkg::ST_D0_NEXT))
        else $error("result word raised outside a draw");

    a_fill_needs_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == afrg_pkg::OP_FILL_WR) |-> !sts.deg_zero)
        else $error("ring fill at degree zero");
`endif

endmodule

[sv/afrg_datapath.sv]
`timescale 1ns / 1ps

module afrg_datapath #(
    parameter int RING_DEPTH    = afrg_pkg::RING_DEPTH_DEF,
    parameter int WARMUP_ROUNDS = afrg_pkg::WARMUP_ROUNDS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [afrg_pkg::CODE_W-1:0]     cfg_wr_data,
    input  logic [afrg_pkg::WORD_W-1:0]     seed_value,
    input  afrg_pkg::dp_cmd_t               cmd,
    output afrg_pkg::dp_sts_t               sts,
    output logic [afrg_pkg::OUT_W-1:0]      random_value
);

    localparam int IDX_W   = $clog2(RING_DEPTH);
    localparam int MAX_DEG = (RING_DEPTH < 63) ? RING_DEPTH : 63;
    localparam int WARM_W  = $clog2(MAX_DEG * WARMUP_ROUNDS + 1);
    localparam int DEG_W   = afrg_pkg::DEG_W;
    localparam int WORD_W  = afrg_pkg::WORD_W;

    function automatic afrg_pkg::degree_t cap_degree(input afrg_pkg::code_t c);
        afrg_pkg::degree_t d;
        d = afrg_pkg::degree_of(c);
        return (d > DEG_W'(MAX_DEG)) ? DEG_W'(MAX_DEG) : d;
    endfunction

    logic [WORD_W-1:0]  ring_mem [RING_DEPTH];

    afrg_pkg::code_t    degree_select_reg;
    afrg_pkg::code_t    active_code_reg;
    logic [IDX_W-1:0]   front_reg;
    logic [IDX_W-1:0]   rear_reg;
    logic [IDX_W-1:0]   k_reg;
    logic [WARM_W-1:0]  warm_reg;
    logic [63:0]        lcg_reg;
    logic [63:0]        prod_reg;
    logic [63:0]        acc_reg;
    logic [WORD_W-1:0]  rd_f_reg;
    logic [WORD_W-1:0]  rd_r_reg;
    logic [afrg_pkg::OUT_W-1:0] random_value_reg;

    afrg_pkg::code_t    load_code;
    afrg_pkg::degree_t  deg_load;
    afrg_pkg::degree_t  deg_cur;
    logic               load_wide;
    logic               cur_wide;
    logic [WORD_W-1:0]  seed_fix;
    logic [IDX_W-1:0]   front_eff;
    logic [IDX_W-1:0]   rear_eff;
    logic [DEG_W-1:0]   front_inc;
    logic [DEG_W-1:0]   rear_inc;
    logic [IDX_W-1:0]   front_adv;
    logic [IDX_W-1:0]   rear_adv;
    logic [WORD_W-1:0]  sum;
    logic [WORD_W-1:0]  small_next;
    logic [WORD_W:0]    wide_lo;
    logic [WORD_W-1:0]  wide_hi;
    logic [WORD_W-1:0]  mul_a;
    logic [WORD_W-1:0]  mul_b;
    logic [63:0]        mul_p;
    logic [WORD_W-1:0]  fill_word;

    assign load_code = cmd.boot ? afrg_pkg::CODE_RESET : afrg_pkg::sat_code(degree_select_reg);
    assign deg_load  = cap_degree(load_code);
    assign load_wide = (load_code == afrg_pkg::CODE_D15) || (load_code == afrg_pkg::CODE_D63);
    assign deg_cur   = cap_degree(active_code_reg);
    assign cur_wide  = (active_code_reg == afrg_pkg::CODE_D15) ||
                       (active_code_reg == afrg_pkg::CODE_D63);

    always_comb begin
        if (cmd.boot) begin
            seed_fix = afrg_pkg::SEED_RESET;
        end else if (deg_load != '0 && seed_value == '0) begin
            seed_fix = WORD_W'(1);
        end else begin
            seed_fix = seed_value;
        end
    end

    // indices at or past the degree wrap to zero
    assign front_eff = (DEG_W'(front_reg) >= deg_cur) ? '0 : front_reg;
    assign rear_eff  = (DEG_W'(rear_reg) >= deg_cur) ? '0 : rear_reg;
    assign front_inc = DEG_W'(front_eff) + DEG_W'(1);
    assign rear_inc  = DEG_W'(rear_eff) + DEG_W'(1);
    assign front_adv = (front_inc >= deg_cur) ? '0 : IDX_W'(front_inc);
    assign rear_adv  = (rear_inc >= deg_cur) ? '0 : IDX_W'(rear_inc);

    assign sum        = rd_f_reg + rd_r_reg;
    assign small_next = prod_reg[31:0] + afrg_pkg::LCG_S_INC;
    assign wide_lo    = {1'b0, acc_reg[31:0]} + 33'd1;
    assign wide_hi    = acc_reg[63:32] + prod_reg[31:0] + {31'b0, wide_lo[32]};
    assign fill_word  = cur_wide ? lcg_reg[63:32] : lcg_reg[31:0];

    always_comb begin
        case (cmd.op)
            afrg_pkg::OP_MUL_P0: begin
                mul_a = afrg_pkg::LCG_L_MUL_LO;
                mul_b = lcg_reg[31:0];
            end
            afrg_pkg::OP_MUL_P1: begin
                mul_a = afrg_pkg::LCG_L_MUL_HI;
                mul_b = lcg_reg[31:0];
            end
            afrg_pkg::OP_MUL_P2: begin
                mul_a = afrg_pkg::LCG_L_MUL_LO;
                mul_b = lcg_reg[63:32];
            end
            default: begin
                mul_a = afrg_pkg::LCG_S_MUL;
                mul_b = lcg_reg[31:0];
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    assign sts.deg_zero  = (deg_cur == '0);
    assign sts.wide      = cur_wide;
    assign sts.fill_last = ((DEG_W'(k_reg) + DEG_W'(1)) == deg_cur);
    assign sts.warm_last = (warm_reg == WARM_W'(1));

    assign random_value = random_value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            degree_select_reg <= afrg_pkg::CODE_RESET;
            active_code_reg   <= afrg_pkg::CODE_RESET;
        end else begin
            if (cfg_wr_en) begin
                degree_select_reg <= cfg_wr_data;
            end
            if (cmd.op == afrg_pkg::OP_LOAD) begin
                active_code_reg <= load_code;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            afrg_pkg::OP_LOAD: begin
                lcg_reg  <= {32'b0, seed_fix};
                k_reg    <= '0;
                warm_reg <= WARM_W'(deg_load) * WARM_W'(WARMUP_ROUNDS);
                if (deg_load != '0) begin
                    front_reg <= load_wide ? IDX_W'(1) : IDX_W'(3);
                    rear_reg  <= '0;
                end
            end
            afrg_pkg::OP_MUL_SMALL: begin
                prod_reg <= mul_p;
            end
            afrg_pkg::OP_NEXT_SMALL: begin
                lcg_reg <= {33'b0, small_next[30:0]};
                if (cmd.out_load) begin
                    random_value_reg <= small_next[30:0];
                end
            end
            afrg_pkg::OP_MUL_P0: begin
                prod_reg <= mul_p;
            end
            afrg_pkg::OP_MUL_P1: begin
                acc_reg  <= prod_reg;
                prod_reg <= mul_p;
            end
            afrg_pkg::OP_MUL_P2: begin
                acc_reg[63:32] <= acc_reg[63:32] + prod_reg[31:0];
                prod_reg       <= mul_p;
            end
            afrg_pkg::OP_NEXT_WIDE: begin
                lcg_reg <= {wide_hi, wide_lo[31:0]};
            end
            afrg_pkg::OP_FILL_WR: begin
                ring_mem[k_reg] <= fill_word;
                k_reg           <= k_reg + IDX_W'(1);
            end
            afrg_pkg::OP_DRAW_RD: begin
                rd_f_reg <= ring_mem[front_eff];
                rd_r_reg <= ring_mem[rear_eff];
            end
            afrg_pkg::OP_DRAW_WR: begin
                ring_mem[front_eff] <= sum;
                front_reg           <= front_adv;
                rear_reg            <= rear_adv;
                if (cmd.warm) begin
                    warm_reg <= warm_reg - WARM_W'(1);
                end
                if (cmd.out_load) begin
                    random_value_reg <= sum[31:1];
                end
            end
            default: begin
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_taps_distinct: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == afrg_pkg::OP_DRAW_RD) |-> (front_eff != rear_eff))
        else $error("front and rear taps coincide");

    a_warm_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == afrg_pkg::OP_DRAW_WR && cmd.warm) |-> (warm_reg != '0))
        else $error("warm-up step with exhausted count");
`endif

endmodule
